// ----- rtl/qtla_pkg.sv -----
// package for the two-level quota alarm: widths, codes, register indexes and shared types
// no dependencies; used by qtla_serial_arith and quota_two_level_alarm_top

package qtla_pkg;

    localparam int BYTE_COUNT_WIDTH_DEF = 48;
    localparam int PCT_W                = 7;
    localparam int FH_W                 = 14;
    localparam int KIND_W               = 3;
    localparam int CFG_IDX_W            = 3;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [FH_W-1:0]  FH_FULL  = 14'd10000;

    localparam logic [KIND_W-1:0] EV_RAISE_SEVERE = 3'd0;
    localparam logic [KIND_W-1:0] EV_RAISE_WARN   = 3'd1;
    localparam logic [KIND_W-1:0] EV_CEASE_SEVERE = 3'd2;
    localparam logic [KIND_W-1:0] EV_CEASE_WARN   = 3'd3;
    localparam logic [KIND_W-1:0] EV_UNAVAILABLE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEVERE_ALARM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEVERE_CEASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_ALARM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_CEASE   = 3'd4;

    localparam logic [PCT_W-1:0] SEVERE_ALARM_RST = 7'd5;
    localparam logic [PCT_W-1:0] SEVERE_CEASE_RST = 7'd10;
    localparam logic [PCT_W-1:0] WARN_ALARM_RST   = 7'd20;
    localparam logic [PCT_W-1:0] WARN_CEASE_RST   = 7'd25;

    // result of the serial arithmetic for one check sample
    typedef struct packed {
        logic            done;
        logic            severe_band;
        logic            warn_band;
        logic            severe_cease_above;
        logic [FH_W-1:0] free_hundredths;
    } qtla_res_t;

    typedef struct packed {
        logic              last;
        logic [FH_W-1:0]   free_hundredths;
        logic [PCT_W-1:0]  level_pct;
        logic [KIND_W-1:0] event_kind;
    } qtla_evt_t;

endpackage

// ----- rtl/qtla_serial_arith.sv -----
// serial arithmetic for one check sample: band compares by shift-add products
// and free space in hundredths by decimal long division, one quotient bit per cycle
// depends on qtla_pkg

module qtla_serial_arith
    import qtla_pkg::*;
#(
    parameter int BYTE_COUNT_WIDTH = BYTE_COUNT_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [BYTE_COUNT_WIDTH-1:0] used_bytes,
    input  logic [BYTE_COUNT_WIDTH-1:0] limit_bytes,
    input  logic [PCT_W-1:0]            severe_alarm_pct,
    input  logic [PCT_W-1:0]            warn_alarm_pct,
    input  logic [PCT_W-1:0]            severe_cease_pct,
    output qtla_res_t                   res
);

    localparam int W  = BYTE_COUNT_WIDTH;
    localparam int PW = W + PCT_W;
    localparam int RW = W + 4;

    typedef enum logic [7:0] {
        A_IDLE  = 8'b0000_0001,
        A_U100  = 8'b0000_0010,
        A_MUL   = 8'b0000_0100,
        A_CMP   = 8'b0000_1000,
        A_DIVI  = 8'b0001_0000,
        A_MUL10 = 8'b0010_0000,
        A_SUB   = 8'b0100_0000,
        A_DONE  = 8'b1000_0000
    } astate_t;

    astate_t         state_reg, state_next;
    logic [W-1:0]    used_reg, used_next;
    logic [PW-1:0]   acc_reg, acc_next;
    logic [PW-1:0]   u100_reg, u100_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [1:0]      tst_reg, tst_next;
    logic [2:0]      band_reg, band_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [1:0]      sub_reg, sub_next;
    logic [3:0]      dig_reg, dig_next;
    logic [FH_W-1:0] q_reg, q_next;
    logic [FH_W-1:0] fh_reg, fh_next;

    logic [PCT_W-1:0] pct_sel;
    logic [PCT_W-1:0] mul_f;
    logic [W-1:0]     mul_a;
    logic [2:0]       bit_idx;
    logic [PW-1:0]    acc_step;
    logic             ge;
    logic             pct_big;
    logic             band_bit;
    logic [RW-1:0]    dvs;
    logic             take;
    logic [3:0]       dig_step;
    logic [FH_W-1:0]  q_step;
    logic [RW-1:0]    rem_x10;

    always_comb begin
        unique case (tst_reg)
            2'd0:    pct_sel = severe_alarm_pct;
            2'd1:    pct_sel = warn_alarm_pct;
            default: pct_sel = severe_cease_pct;
        endcase
        mul_f    = (state_reg == A_U100) ? PCT_FULL : PCT_W'(PCT_FULL - pct_sel);
        mul_a    = (state_reg == A_U100) ? used_reg : limit_bytes;
        bit_idx  = 3'd6 - cnt_reg;
        acc_step = PW'({acc_reg[PW-2:0], 1'b0}
                   + (mul_f[bit_idx] ? {{PCT_W{1'b0}}, mul_a} : {PW{1'b0}}));
        ge       = u100_reg >= acc_reg;
        pct_big  = pct_sel >= PCT_FULL;
        band_bit = (tst_reg == 2'd2) ? (!pct_big && !ge) : (pct_big || ge);
        dvs      = {4'b0000, limit_bytes} << sub_reg;
        take     = rem_reg >= dvs;
        dig_step = dig_reg | (take ? (4'b0001 << sub_reg) : 4'b0000);
        q_step   = FH_W'((q_reg << 3) + (q_reg << 1) + {{(FH_W-4){1'b0}}, dig_step});
        rem_x10  = RW'((rem_reg << 3) + (rem_reg << 1));
    end

    always_comb begin
        state_next = state_reg;
        used_next  = used_reg;
        acc_next   = acc_reg;
        u100_next  = u100_reg;
        cnt_next   = cnt_reg;
        tst_next   = tst_reg;
        band_next  = band_reg;
        rem_next   = rem_reg;
        sub_next   = sub_reg;
        dig_next   = dig_reg;
        q_next     = q_reg;
        fh_next    = fh_reg;
        unique case (state_reg)
            A_IDLE: begin
                if (start) begin
                    used_next  = used_bytes;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = A_U100;
                end
            end
            A_U100: begin
                if (cnt_reg == 3'd6) begin
                    u100_next  = acc_step;
                    acc_next   = '0;
                    cnt_next   = '0;
                    tst_next   = '0;
                    state_next = A_MUL;
                end else begin
                    acc_next = acc_step;
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            A_MUL: begin
                acc_next = acc_step;
                if (cnt_reg == 3'd6) begin
                    state_next = A_CMP;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            A_CMP: begin
                band_next[tst_reg] = band_bit;
                acc_next = '0;
                cnt_next = '0;
                if (tst_reg == 2'd2) begin
                    state_next = A_DIVI;
                end else begin
                    tst_next   = tst_reg + 2'd1;
                    state_next = A_MUL;
                end
            end
            A_DIVI: begin
                if (used_reg >= limit_bytes) begin
                    fh_next    = '0;
                    state_next = A_DONE;
                end else begin
                    rem_next   = {4'b0000, used_reg};
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = A_MUL10;
                end
            end
            A_MUL10: begin
                rem_next   = rem_x10;
                dig_next   = '0;
                sub_next   = 2'd3;
                state_next = A_SUB;
            end
            A_SUB: begin
                if (take) begin
                    rem_next = RW'(rem_reg - dvs);
                end
                dig_next = dig_step;
                if (sub_reg == 2'd0) begin
                    q_next = q_step;
                    if (cnt_reg == 3'd3) begin
                        fh_next    = FH_W'(FH_FULL - q_step);
                        state_next = A_DONE;
                    end else begin
                        cnt_next   = cnt_reg + 3'd1;
                        state_next = A_MUL10;
                    end
                end else begin
                    sub_next = sub_reg - 2'd1;
                end
            end
            A_DONE: begin
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
        used_reg <= used_next;
        acc_reg  <= acc_next;
        u100_reg <= u100_next;
        cnt_reg  <= cnt_next;
        tst_reg  <= tst_next;
        band_reg <= band_next;
        rem_reg  <= rem_next;
        sub_reg  <= sub_next;
        dig_reg  <= dig_next;
        q_reg    <= q_next;
        fh_reg   <= fh_next;
    end

    assign res.done               = (state_reg == A_DONE);
    assign res.severe_band        = band_reg[0];
    assign res.warn_band          = band_reg[1];
    assign res.severe_cease_above = band_reg[2];
    assign res.free_hundredths    = fh_reg;

endmodule

// ----- rtl/quota_two_level_alarm_top.sv -----
// top level of the two-level quota alarm: stream ports, register file, alarm flags,
// event decision and a two-entry event buffer ahead of the output register
// depends on qtla_pkg and qtla_serial_arith
//
// sequencing: a check sample with a nonzero limit runs a shift-add product for 100*used,
// three product-and-compare passes, a setup step and decimal long division for 4 digits,
// then passes through the result state, the event buffer and the output register to m_tvalid;
// with used at or above the limit the division is skipped; stop and folder-absent requests
// go straight to the event buffer and the output register; a check sample with a zero limit
// raises no event
// input hold: a new request is taken only in the idle state, once every event of the last one
// has been loaded into the output register, so m_tready stalls hold the input longer
// reset: synchronous, active low; both alarm flags clear, registers take their defaults,
// event buffer and output register empty

module quota_two_level_alarm_top
    import qtla_pkg::*;
#(
    parameter int BYTE_COUNT_WIDTH = BYTE_COUNT_WIDTH_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // config write channel
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]                       cfg_index,
    input  logic [BYTE_COUNT_WIDTH-1:0]                cfg_data,
    // request channel
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // folder_present, used_bytes, zero fill
    input  logic [((BYTE_COUNT_WIDTH + 8) / 8) * 8-1:0] s_tdata,
    // action
    input  logic                                       s_tuser,
    // event channel
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // level_pct, free_hundredths, zero fill
    output logic [23:0]                                m_tdata,
    // event_kind
    output logic [KIND_W-1:0]                          m_tuser,
    output logic                                       m_tlast
);

    localparam int W = BYTE_COUNT_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [W-1:0]     limit_reg;
    logic [PCT_W-1:0] sev_alarm_reg, sev_cease_reg, warn_alarm_reg, warn_cease_reg;
    logic             sev_reg, sev_next;
    logic             warn_reg, warn_next;
    qtla_evt_t        evq_reg [2];
    qtla_evt_t        evq_next [2];
    logic [1:0]       evn_reg, evn_next;
    qtla_evt_t        out_reg, out_next;
    logic             out_vld_reg, out_vld_next;

    logic             s_acc;
    logic             present;
    logic             start;
    logic             load;
    qtla_res_t        arith_res;
    qtla_evt_t        evs [2];
    logic [1:0]       n;

    function automatic qtla_evt_t mk_evt(logic [KIND_W-1:0] kind, logic [PCT_W-1:0] lvl,
                                         logic [FH_W-1:0] fh);
        qtla_evt_t e;
        e.event_kind      = kind;
        e.level_pct       = lvl;
        e.free_hundredths = fh;
        e.last            = 1'b0;
        return e;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign present   = s_tdata[0];
    assign start     = s_acc && !s_tuser && present && (limit_reg != '0);

    qtla_serial_arith #(
        .BYTE_COUNT_WIDTH (BYTE_COUNT_WIDTH)
    ) u_arith (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .start            (start),
        .used_bytes       (s_tdata[W:1]),
        .limit_bytes      (limit_reg),
        .severe_alarm_pct (sev_alarm_reg),
        .warn_alarm_pct   (warn_alarm_reg),
        .severe_cease_pct (sev_cease_reg),
        .res              (arith_res)
    );

    // event decision
    always_comb begin
        evs[0]    = '0;
        evs[1]    = '0;
        n         = 2'd0;
        sev_next  = sev_reg;
        warn_next = warn_reg;
        if (s_acc && s_tuser) begin
            if (sev_reg) begin
                evs[n[0]] = mk_evt(EV_CEASE_SEVERE, sev_cease_reg, '0);
                n = n + 2'd1;
            end
            if (warn_reg) begin
                evs[n[0]] = mk_evt(EV_CEASE_WARN, warn_cease_reg, '0);
                n = n + 2'd1;
            end
            sev_next  = 1'b0;
            warn_next = 1'b0;
        end else if (s_acc && !present) begin
            evs[0] = mk_evt(EV_UNAVAILABLE, '0, '0);
            n      = 2'd1;
        end else if (state_reg == ST_BUSY && arith_res.done) begin
            if (arith_res.severe_band) begin
                if (warn_reg) begin
                    evs[n[0]] = mk_evt(EV_CEASE_WARN, warn_cease_reg,
                                       arith_res.free_hundredths);
                    n = n + 2'd1;
                    warn_next = 1'b0;
                end
                if (!sev_reg) begin
                    evs[n[0]] = mk_evt(EV_RAISE_SEVERE, sev_alarm_reg,
                                       arith_res.free_hundredths);
                    n = n + 2'd1;
                    sev_next = 1'b1;
                end
            end else if (arith_res.warn_band) begin
                if (sev_reg) begin
                    if (arith_res.severe_cease_above) begin
                        evs[0] = mk_evt(EV_CEASE_SEVERE, sev_cease_reg,
                                        arith_res.free_hundredths);
                        evs[1] = mk_evt(EV_RAISE_WARN, warn_alarm_reg,
                                        arith_res.free_hundredths);
                        n = 2'd2;
                        sev_next  = 1'b0;
                        warn_next = 1'b1;
                    end
                end else if (!warn_reg) begin
                    evs[0] = mk_evt(EV_RAISE_WARN, warn_alarm_reg,
                                    arith_res.free_hundredths);
                    n = 2'd1;
                    warn_next = 1'b1;
                end
            end else begin
                if (sev_reg) begin
                    evs[n[0]] = mk_evt(EV_CEASE_SEVERE, sev_cease_reg,
                                       arith_res.free_hundredths);
                    n = n + 2'd1;
                    sev_next = 1'b0;
                end
                if (warn_reg) begin
                    evs[n[0]] = mk_evt(EV_CEASE_WARN, warn_cease_reg,
                                       arith_res.free_hundredths);
                    n = n + 2'd1;
                    warn_next = 1'b0;
                end
            end
        end
        if (n == 2'd1) begin
            evs[0].last = 1'b1;
        end
        if (n == 2'd2) begin
            evs[1].last = 1'b1;
        end
    end

    // sequencing, event buffer and output register
    assign load = (state_reg == ST_EMIT) && (!out_vld_reg || m_tready);

    always_comb begin
        state_next   = state_reg;
        evq_next[0]  = evq_reg[0];
        evq_next[1]  = evq_reg[1];
        evn_next     = evn_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_BUSY;
                end else if (n != 2'd0) begin
                    evq_next[0] = evs[0];
                    evq_next[1] = evs[1];
                    evn_next    = n;
                    state_next  = ST_EMIT;
                end
            end
            ST_BUSY: begin
                if (arith_res.done) begin
                    if (n != 2'd0) begin
                        evq_next[0] = evs[0];
                        evq_next[1] = evs[1];
                        evn_next    = n;
                        state_next  = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (load) begin
                    out_next     = evq_reg[0];
                    out_vld_next = 1'b1;
                    evq_next[0]  = evq_reg[1];
                    evn_next     = evn_reg - 2'd1;
                    if (evn_reg == 2'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sev_reg        <= 1'b0;
            warn_reg       <= 1'b0;
            evn_reg        <= 2'd0;
            out_vld_reg    <= 1'b0;
            limit_reg      <= '0;
            sev_alarm_reg  <= SEVERE_ALARM_RST;
            sev_cease_reg  <= SEVERE_CEASE_RST;
            warn_alarm_reg <= WARN_ALARM_RST;
            warn_cease_reg <= WARN_CEASE_RST;
        end else begin
            state_reg   <= state_next;
            sev_reg     <= sev_next;
            warn_reg    <= warn_next;
            evn_reg     <= evn_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_LIMIT:        limit_reg      <= cfg_data;
                    REG_SEVERE_ALARM: sev_alarm_reg  <= cfg_data[PCT_W-1:0];
                    REG_SEVERE_CEASE: sev_cease_reg  <= cfg_data[PCT_W-1:0];
                    REG_WARN_ALARM:   warn_alarm_reg <= cfg_data[PCT_W-1:0];
                    REG_WARN_CEASE:   warn_cease_reg <= cfg_data[PCT_W-1:0];
                    default: ;
                endcase
            end
        end
        evq_reg[0] <= evq_next[0];
        evq_reg[1] <= evq_next[1];
        out_reg    <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_reg.free_hundredths, out_reg.level_pct};
    assign m_tuser  = out_reg.event_kind;
    assign m_tlast  = out_reg.last;

    a_done_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        arith_res.done |-> state_reg == ST_BUSY)
        else $error("arithmetic result outside busy state");

    a_emit_has_events: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> (evn_reg == 2'd1 || evn_reg == 2'd2))
        else $error("emit state with empty event buffer");

    a_final_event_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && evn_reg == 2'd1) |=> (m_tvalid && m_tlast))
        else $error("final event of a request not marked last");

    a_never_both_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sev_reg && warn_reg))
        else $error("severe and warning alarms raised together");

endmodule
